### rtl/rrjs_pkg.sv
package rrjs_pkg;

   localparam int MAX_JOBS = 64;
   localparam int ADDR_W   = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   localparam logic [1:0] MODE_RR   = 2'd0;
   localparam logic [1:0] MODE_PRIO = 2'd1;
   localparam logic [1:0] MODE_SRF  = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   localparam logic [0:0] CSR_FULL_SLICE = 1'b0;
   localparam logic [0:0] CSR_SCHED_MODE = 1'b1;

   localparam logic [7:0] FULL_SLICE_RST = 8'd5;
   localparam logic [1:0] PRIO_LOW       = 2'd2;

   typedef struct packed {
      logic       op;
      logic [1:0] job_class;
      logic [1:0] job_priority;
      logic [15:0] job_length;
      logic [6:0] io_odds;
      logic [6:0] io_draw;
      logic [7:0] short_slice;
   } req_type;

   typedef struct packed {
      logic        served;
      logic        finished;
      logic [1:0]  done_class;
      logic [1:0]  done_priority;
      logic [31:0] elapsed_time;
      logic [15:0] remaining_length;
      logic        load_rejected;
      logic        all_empty;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  cls;
      logic [1:0]  pri;
      logic [6:0]  odds;
      logic [15:0] len;
   } job_type;

   typedef struct packed {
      logic              fin;
      logic [15:0]       new_len;
      logic [31:0]       clock_next;
   } slice_res_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] pass_left;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SORT_RDV,
      ST_SORT_GETV,
      ST_SORT_RDM,
      ST_SORT_CMP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SERVE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRBACK,
      ST_RESP
   } state_type;

   // circular store position head + off
   function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                             input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, head} + {1'b0, off};
      if (sum >= (CNT_W + 1)'(MAX_JOBS)) begin
         sum = sum - (CNT_W + 1)'(MAX_JOBS);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

### rtl/rrjs_intf.sv
interface rrjs_req_if;
   logic              valid;
   logic              ready;
   rrjs_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rrjs_rsp_if;
   logic              valid;
   logic              ready;
   rrjs_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/rrjs_slice.sv
module rrjs_slice (
   input  logic [15:0]                 len,
   input  logic [6:0]                  odds,
   input  logic [6:0]                  draw,
   input  logic [7:0]                  short_slice,
   input  logic [7:0]                  full_slice,
   input  logic [31:0]                 clock_total,
   output rrjs_pkg::slice_res_type     res
);
   logic [7:0]  full_eff;
   logic [7:0]  ss_c;
   logic [7:0]  quantum;
   logic [15:0] used;
   logic [32:0] sum;

   always_comb begin
      full_eff = (full_slice == 8'd0) ? 8'd1 : full_slice;
      ss_c = (short_slice == 8'd0) ? 8'd1 : short_slice;
      if (ss_c > full_eff) begin
         ss_c = full_eff;
      end
      quantum = (draw > odds) ? ss_c : full_eff;
      res.fin = len <= {8'd0, quantum};
      used = res.fin ? len : {8'd0, quantum};
      res.new_len = len - used;
      sum = {1'b0, clock_total} + {17'd0, used};
      res.clock_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   end
endmodule

### rtl/rrjs_ctrl.sv
module rrjs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rrjs_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rrjs_pkg::rsp_type    rsp_data,
   input  logic [7:0]           full_slice,
   input  logic [1:0]           sched_mode,
   output rrjs_pkg::stat_type   stat
);
   localparam int CW = rrjs_pkg::CNT_W;
   localparam int AW = rrjs_pkg::ADDR_W;

   rrjs_pkg::state_type state_ff, state_in;

   rrjs_pkg::job_type mem [rrjs_pkg::MAX_JOBS];
   rrjs_pkg::job_type rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     waddr, raddr;
   rrjs_pkg::job_type wdata;

   rrjs_pkg::req_type item_ff;
   rrjs_pkg::job_type job_ff, v_ff, new_job;
   rrjs_pkg::rsp_type res_ff;
   rrjs_pkg::rsp_type res_init;
   logic [AW-1:0]     head_ff;
   logic [CW-1:0]     count_ff, pass_ff, n_ff, idx_ff, p_ff;
   logic [CW-1:0]     pcnt_ff [3];
   logic [31:0]       clock_ff;
   logic [1:0]        target;
   logic [1:0]        pri_c;
   logic              scan_more, ins_done, shift_more, cmp_ge;
   logic              pass_start, sort_start;

   rrjs_pkg::slice_res_type sres;

   rrjs_slice u_slice (
      .len         (job_ff.len),
      .odds        (job_ff.odds),
      .draw        (item_ff.io_draw),
      .short_slice (item_ff.short_slice),
      .full_slice  (full_slice),
      .clock_total (clock_ff),
      .res         (sres)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      pri_c = (item_ff.job_priority > rrjs_pkg::PRIO_LOW) ? rrjs_pkg::PRIO_LOW
                                                          : item_ff.job_priority;
      new_job = '{cls: item_ff.job_class, pri: pri_c, odds: item_ff.io_odds,
                  len: item_ff.job_length};
      if (pcnt_ff[0] != '0) target = 2'd0;
      else if (pcnt_ff[1] != '0) target = 2'd1;
      else target = rrjs_pkg::PRIO_LOW;
      scan_more = (sched_mode == rrjs_pkg::MODE_PRIO) && (idx_ff + 1'b1 < n_ff)
                  && (rdata_ff.pri != target);
      ins_done = (idx_ff + 1'b1 == n_ff);
      shift_more = (idx_ff + 1'b1 < n_ff);
      cmp_ge = rdata_ff.len >= v_ff.len;
      pass_start = (item_ff.op == rrjs_pkg::OP_RUN) && (count_ff != '0)
                   && (pass_ff == '0);
      // the sort walk starts at the second job; a plain serve scans from the front
      sort_start = pass_start && (sched_mode == rrjs_pkg::MODE_SRF)
                   && (count_ff > CW'(1));
      res_init = '0;
      res_init.load_rejected = (item_ff.op == rrjs_pkg::OP_LOAD)
                               && (count_ff >= CW'(rrjs_pkg::MAX_JOBS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrjs_pkg::ST_IDLE:
            if (req_valid) state_in = rrjs_pkg::ST_DECIDE;
         rrjs_pkg::ST_DECIDE: begin
            if (item_ff.op == rrjs_pkg::OP_LOAD || count_ff == '0) begin
               state_in = rrjs_pkg::ST_RESP;
            end else if (pass_ff == '0 && sched_mode == rrjs_pkg::MODE_SRF
                         && count_ff > CW'(1)) begin
               state_in = rrjs_pkg::ST_SORT_RDV;
            end else begin
               state_in = rrjs_pkg::ST_SCAN_RD;
            end
         end
         rrjs_pkg::ST_SORT_RDV:  state_in = rrjs_pkg::ST_SORT_GETV;
         rrjs_pkg::ST_SORT_GETV: state_in = rrjs_pkg::ST_SORT_RDM;
         rrjs_pkg::ST_SORT_RDM: begin
            if (p_ff != '0) state_in = rrjs_pkg::ST_SORT_CMP;
            else state_in = ins_done ? rrjs_pkg::ST_SCAN_RD : rrjs_pkg::ST_SORT_RDV;
         end
         rrjs_pkg::ST_SORT_CMP: begin
            if (cmp_ge) state_in = rrjs_pkg::ST_SORT_RDM;
            else state_in = ins_done ? rrjs_pkg::ST_SCAN_RD : rrjs_pkg::ST_SORT_RDV;
         end
         rrjs_pkg::ST_SCAN_RD:  state_in = rrjs_pkg::ST_SCAN_CHK;
         rrjs_pkg::ST_SCAN_CHK:
            state_in = scan_more ? rrjs_pkg::ST_SCAN_RD : rrjs_pkg::ST_SERVE;
         rrjs_pkg::ST_SERVE:
            state_in = (idx_ff != '0) ? rrjs_pkg::ST_SHIFT_RD : rrjs_pkg::ST_WRBACK;
         rrjs_pkg::ST_SHIFT_RD:
            state_in = shift_more ? rrjs_pkg::ST_SHIFT_WR : rrjs_pkg::ST_WRBACK;
         rrjs_pkg::ST_SHIFT_WR: state_in = rrjs_pkg::ST_SHIFT_RD;
         rrjs_pkg::ST_WRBACK:   state_in = rrjs_pkg::ST_RESP;
         rrjs_pkg::ST_RESP:
            if (rsp_ready) state_in = rrjs_pkg::ST_IDLE;
         default: state_in = rrjs_pkg::ST_IDLE;
      endcase
   end

   // outputs and store port
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      mem_we = 1'b0;
      waddr = rrjs_pkg::slot(head_ff, idx_ff);
      raddr = rrjs_pkg::slot(head_ff, idx_ff);
      wdata = rdata_ff;
      unique case (state_ff)
         rrjs_pkg::ST_IDLE: req_ready = 1'b1;
         rrjs_pkg::ST_DECIDE: begin
            if (item_ff.op == rrjs_pkg::OP_LOAD && count_ff < CW'(rrjs_pkg::MAX_JOBS)) begin
               mem_we = 1'b1;
               waddr = rrjs_pkg::slot(head_ff, count_ff);
               wdata = new_job;
            end
         end
         rrjs_pkg::ST_SORT_RDM: begin
            if (p_ff == '0) begin
               mem_we = 1'b1;
               waddr = rrjs_pkg::slot(head_ff, '0);
               wdata = v_ff;
            end else begin
               raddr = rrjs_pkg::slot(head_ff, p_ff - 1'b1);
            end
         end
         rrjs_pkg::ST_SORT_CMP: begin
            mem_we = 1'b1;
            waddr = rrjs_pkg::slot(head_ff, p_ff);
            wdata = cmp_ge ? rdata_ff : v_ff;
         end
         rrjs_pkg::ST_SHIFT_RD: raddr = rrjs_pkg::slot(head_ff, idx_ff + 1'b1);
         rrjs_pkg::ST_SHIFT_WR: mem_we = 1'b1;
         rrjs_pkg::ST_WRBACK: begin
            mem_we = !res_ff.finished;
            waddr = rrjs_pkg::slot(head_ff, count_ff);
            wdata = '{cls: job_ff.cls, pri: job_ff.pri, odds: job_ff.odds,
                      len: res_ff.remaining_length};
         end
         rrjs_pkg::ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrjs_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pass_ff  <= '0;
         clock_ff <= '0;
         pcnt_ff  <= '{default: '0};
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            rrjs_pkg::ST_IDLE:
               if (req_valid) item_ff <= req_data;
            rrjs_pkg::ST_DECIDE: begin
               res_ff <= res_init;
               n_ff <= count_ff;
               idx_ff <= sort_start ? CW'(1) : '0;
               if (item_ff.op == rrjs_pkg::OP_LOAD) begin
                  if (count_ff < CW'(rrjs_pkg::MAX_JOBS)) begin
                     count_ff <= count_ff + 1'b1;
                     pcnt_ff[pri_c] <= pcnt_ff[pri_c] + 1'b1;
                  end
               end else if (pass_start) begin
                  pass_ff <= count_ff;
               end
            end
            rrjs_pkg::ST_SORT_GETV: begin
               v_ff <= rdata_ff;
               p_ff <= idx_ff;
            end
            rrjs_pkg::ST_SORT_RDM:
               if (p_ff == '0) idx_ff <= ins_done ? '0 : idx_ff + 1'b1;
            rrjs_pkg::ST_SORT_CMP: begin
               if (cmp_ge) p_ff <= p_ff - 1'b1;
               else idx_ff <= ins_done ? '0 : idx_ff + 1'b1;
            end
            rrjs_pkg::ST_SCAN_CHK: begin
               if (scan_more) idx_ff <= idx_ff + 1'b1;
               else job_ff <= rdata_ff;
            end
            rrjs_pkg::ST_SERVE: begin
               clock_ff <= sres.clock_next;
               if (pass_ff != '0) pass_ff <= pass_ff - 1'b1;
               if (idx_ff == '0) head_ff <= rrjs_pkg::slot(head_ff, CW'(1));
               count_ff <= count_ff - 1'b1;
               if (sres.fin && job_ff.pri != 2'd3 && pcnt_ff[job_ff.pri] != '0) begin
                  pcnt_ff[job_ff.pri] <= pcnt_ff[job_ff.pri] - 1'b1;
               end
               res_ff.served <= 1'b1;
               res_ff.finished <= sres.fin;
               res_ff.done_class <= job_ff.cls;
               res_ff.done_priority <= job_ff.pri;
               res_ff.remaining_length <= sres.new_len;
            end
            rrjs_pkg::ST_SHIFT_WR: idx_ff <= idx_ff + 1'b1;
            rrjs_pkg::ST_WRBACK:
               if (!res_ff.finished) count_ff <= count_ff + 1'b1;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_data = res_ff;
      rsp_data.elapsed_time = clock_ff;
      rsp_data.all_empty = (count_ff == '0);
      stat.count = count_ff;
      stat.pass_left = pass_ff;
   end
endmodule

### rtl/round_robin_job_scheduler_top.sv
// channel   dir  handshake            word
// req_chan  in   valid/ready          op, job fields, io_draw, short_slice
// rsp_chan  out  valid/ready          served, finished, class, prio, time, len
// csr_*     in   csr_we, no ready     csr_index selects full_slice / sched_mode
//
// Load, or run on an empty store: straight from accept to result. Run: reads each
// scanned job (only the front unless strict priority), then shifts jobs down
// when the served job is not the front; the store has one read and one write port.
// Shortest-first pass start adds an insertion sort over the store, each insertion
// moving every job that is not shorter up one place until the new job's spot is found.
// Reset is synchronous; the store needs no clearing. One word at a time:
// req_ready is low from accept until the result word is taken.
module round_robin_job_scheduler_top (
   input  logic          clock,
   input  logic          reset,
   rrjs_req_if.sink      req_chan,
   rrjs_rsp_if.source    rsp_chan,
   input  logic          csr_we,
   input  logic [0:0]    csr_index,
   input  logic [7:0]    csr_wdata
);
   logic [7:0] full_slice_ff;
   logic [1:0] sched_mode_ff;
   rrjs_pkg::stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_slice_ff <= rrjs_pkg::FULL_SLICE_RST;
         sched_mode_ff <= rrjs_pkg::MODE_RR;
      end else if (csr_we) begin
         unique case (csr_index)
            rrjs_pkg::CSR_FULL_SLICE: full_slice_ff <= csr_wdata;
            rrjs_pkg::CSR_SCHED_MODE: sched_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   rrjs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_data   (req_chan.data),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_data   (rsp_chan.data),
      .full_slice (full_slice_ff),
      .sched_mode (sched_mode_ff),
      .stat       (stat)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("ready while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("accepted a second word");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= rrjs_pkg::CNT_W'(rrjs_pkg::MAX_JOBS))
      else $error("store overfilled");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      stat.pass_left <= stat.count)
      else $error("pass longer than job count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.data.all_empty == (stat.count == '0)))
      else $error("empty flag mismatch");
endmodule

### tb/rrjs_tb_intf.sv
`timescale 1ns / 1ps
// Channel interfaces come from the RTL (rrjs_intf.sv); only the CSR interface is defined here.
interface rrjs_csr_if;
   logic       we;
   logic [0:0] index;
   logic [7:0] wdata;
endinterface

### tb/tb.sv
`timescale 1ns / 1ps

class job_scoreboard;
   rrjs_pkg::job_type  store [rrjs_pkg::MAX_JOBS];
   int unsigned        head, count, pass_left;
   int unsigned        prio_count [3];
   logic [31:0]        clock_total;
   logic [7:0]         full_slice;
   logic [1:0]         mode;
   rrjs_pkg::rsp_type  pending [$];
   int                 errors;

   function void reset_state();
      head = 0; count = 0; pass_left = 0; clock_total = 0;
      foreach (prio_count[i]) prio_count[i] = 0;
      full_slice = rrjs_pkg::FULL_SLICE_RST; mode = rrjs_pkg::MODE_RR;
      pending.delete(); errors = 0;
   endfunction

   function int unsigned pos(int unsigned off);
      return (head + off) % rrjs_pkg::MAX_JOBS;
   endfunction

   function void sort_by_length();
      rrjs_pkg::job_type buf_q [$];
      int j;
      for (int i = 0; i < count; i++) begin
         j = 0;
         while (j < i && buf_q[j].len < store[pos(i)].len) j++;
         buf_q.insert(j, store[pos(i)]);
      end
      for (int i = 0; i < count; i++) store[pos(i)] = buf_q[i];
   endfunction

   function void note_word(rrjs_pkg::req_type r);
      rrjs_pkg::rsp_type e;
      rrjs_pkg::job_type jb;
      int unsigned k, n, want, quantum, used, full, ss;
      logic [1:0] p;
      e = '0;
      if (r.op == rrjs_pkg::OP_LOAD) begin
         if (count >= rrjs_pkg::MAX_JOBS) e.load_rejected = 1'b1;
         else begin
            p = (r.job_priority > rrjs_pkg::PRIO_LOW) ? rrjs_pkg::PRIO_LOW : r.job_priority;
            store[pos(count)] = '{r.job_class, p, r.io_odds, r.job_length};
            count++; prio_count[p]++;
         end
      end else if (count != 0) begin
         n = count;
         if (pass_left == 0) begin
            pass_left = n;
            if (mode == rrjs_pkg::MODE_SRF) sort_by_length();
         end
         k = 0;
         if (mode == rrjs_pkg::MODE_PRIO) begin
            want = prio_count[0] > 0 ? 0 : (prio_count[1] > 0 ? 1 : 2);
            while (k + 1 < n && store[pos(k)].pri != want) k++;
         end
         jb = store[pos(k)];
         full = (full_slice == 0) ? 1 : full_slice;
         quantum = full;
         if (r.io_draw > jb.odds) begin
            ss = r.short_slice;
            if (ss < 1) ss = 1;
            if (ss > full) ss = full;
            quantum = ss;
         end
         used = jb.len < quantum ? jb.len : quantum;
         e.finished = jb.len <= quantum;
         if (64'(clock_total) + used > 64'hFFFF_FFFF) clock_total = '1;
         else clock_total += 32'(used);
         if (pass_left > 0) pass_left--;
         if (k == 0) head = (head + 1) % rrjs_pkg::MAX_JOBS;
         else for (int i = k; i + 1 < n; i++) store[pos(i)] = store[pos(i + 1)];
         count--;
         if (e.finished) begin
            if (prio_count[jb.pri] > 0) prio_count[jb.pri]--;
         end else begin
            store[pos(count)] = jb;
            store[pos(count)].len = jb.len - 16'(used);
            count++;
         end
         e.served = 1'b1; e.done_class = jb.cls; e.done_priority = jb.pri;
         e.remaining_length = jb.len - 16'(used);
      end
      e.elapsed_time = clock_total;
      e.all_empty = (count == 0);
      pending.push_back(e);
   endfunction

   function void check_word(rrjs_pkg::rsp_type a);
      rrjs_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected result word"); errors++; return;
      end
      e = pending.pop_front();
      if (a.served !== e.served) begin
         $error("served exp %0d got %0d", e.served, a.served); errors++; end
      if (a.finished !== e.finished) begin
         $error("finished exp %0d got %0d", e.finished, a.finished); errors++; end
      if (a.done_class !== e.done_class) begin
         $error("done_class exp %0d got %0d", e.done_class, a.done_class); errors++; end
      if (a.done_priority !== e.done_priority) begin
         $error("done_priority exp %0d got %0d", e.done_priority, a.done_priority);
         errors++; end
      if (a.elapsed_time !== e.elapsed_time) begin
         $error("elapsed_time exp %0d got %0d", e.elapsed_time, a.elapsed_time);
         errors++; end
      if (a.remaining_length !== e.remaining_length) begin
         $error("remaining_length exp %0d got %0d", e.remaining_length,
                a.remaining_length); errors++; end
      if (a.load_rejected !== e.load_rejected) begin
         $error("load_rejected exp %0d got %0d", e.load_rejected, a.load_rejected);
         errors++; end
      if (a.all_empty !== e.all_empty) begin
         $error("all_empty exp %0d got %0d", e.all_empty, a.all_empty); errors++; end
   endfunction
endclass

module tb;
   logic clock = 0, reset = 1;
   int unsigned cycles = 0;
   int unsigned gap;

   rrjs_req_if req_chan();
   rrjs_rsp_if rsp_chan();
   rrjs_csr_if csr();
   job_scoreboard sb = new();

   round_robin_job_scheduler_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr.we), .csr_index(csr.index), .csr_wdata(csr.wdata));

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: random stall per word
   always @(posedge clock) begin
      if (reset) begin
         gap <= 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) sb.check_word(rsp_chan.data);
         if (gap > 0) begin
            gap <= gap - 1; rsp_chan.ready <= 1'b0;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            rsp_chan.ready <= 1'b0;
         end else rsp_chan.ready <= 1'b1;
      end
   end

   task automatic write_reg(logic [0:0] idx, logic [7:0] val);
      @(posedge clock);
      csr.we <= 1'b1; csr.index <= idx; csr.wdata <= val;
      @(posedge clock);
      csr.we <= 1'b0;
      if (idx == rrjs_pkg::CSR_FULL_SLICE) sb.full_slice = val;
      else sb.mode = val[1:0];
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // valid stays high after an accept only when the next word follows at once
   task automatic send(rrjs_pkg::req_type r, bit burst);
      int w;
      w = burst ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
         req_chan.valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_chan.valid <= 1'b1; req_chan.data <= r;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_word(r);
   endtask

   function automatic rrjs_pkg::req_type load_word(int len, int pri);
      rrjs_pkg::req_type r;
      r = '0;
      r.op = rrjs_pkg::OP_LOAD;
      r.job_class = 2'($urandom_range(0, 3));
      r.job_length = 16'(len);
      r.job_priority = 2'(pri);
      r.io_odds = 7'($urandom_range(0, 127));
      r.io_draw = 7'($urandom);
      r.short_slice = 8'($urandom);
      return r;
   endfunction

   function automatic rrjs_pkg::req_type run_word();
      rrjs_pkg::req_type r;
      r = '0;
      r.op = rrjs_pkg::OP_RUN;
      r.job_class = 2'($urandom);
      r.job_priority = 2'($urandom);
      r.job_length = 16'($urandom);
      r.io_odds = 7'($urandom);
      r.io_draw = 7'($urandom_range(0, 127));
      r.short_slice = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 12));
      return r;
   endfunction

   initial begin
      rrjs_pkg::req_type r;
      bit burst;
      logic [7:0] slices [4];
      slices = '{8'd5, 8'd1, 8'd255, 8'd0};
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      csr.we = 1'b0;
      csr.index = rrjs_pkg::CSR_FULL_SLICE;
      csr.wdata = '0;
      sb.reset_state();
      repeat (7) @(posedge clock);
      reset <= 0;
      // directed: empty run, extremes, priority three, zero length
      send(run_word(), 0);
      send(load_word(0, 3), 0);
      send(load_word(16'hFFFF, 0), 0);
      r = load_word(7, 1); r.io_odds = 7'd127; r.job_class = 2'd3; send(r, 0);
      r = load_word(3, 2); r.io_odds = 7'd0; r.job_class = 2'd0; send(r, 0);
      for (int i = 0; i < 6; i++) begin
         r = run_word(); r.io_draw = i[0] ? 7'd127 : 7'd0;
         r.short_slice = i[1] ? 8'hFF : 8'h00; send(r, 0);
      end
      // fill past capacity
      for (int i = 0; i < rrjs_pkg::MAX_JOBS + 2; i++)
         send(load_word($urandom_range(0, 9), 1), 1);
      for (int i = 0; i < 4; i++) send(run_word(), 0);
      drain();
      for (int ph = 0; ph < 12; ph++) begin
         write_reg(rrjs_pkg::CSR_FULL_SLICE,
                   ph < 4 ? slices[ph] : 8'($urandom_range(1, 255)));
         write_reg(rrjs_pkg::CSR_SCHED_MODE, 8'(ph % 4));
         burst = ph[0];
         for (int i = 0; i < 90; i++) begin
            if ($urandom_range(0, 2) == 0 || sb.count == 0)
               send(load_word($urandom_range(0, 7) == 0 ? int'($urandom)
                                                        : $urandom_range(0, 40),
                              $urandom_range(0, 3)), burst && i > 45);
            else send(run_word(), burst && i > 45);
         end
         // try to empty the store once
         if (ph == 5)
            for (int t = 0; t < 200 && sb.count != 0; t++) send(run_word(), 0);
         drain();
      end
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
